>>> rtl/upc_pkg.sv
// upc_pkg: shared types, character constants and helper functions
// for the URL percent codec. No dependencies.
package upc_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] NIBBLE_MSK = 8'h0F;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_UA     = 8'h41;
  localparam logic [7:0] CHR_LA     = 8'h61;
  localparam int         MAX_BEATS  = 3;

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  typedef enum logic [1:0] {
    PH_PLAIN  = 2'd0,
    PH_PCT    = 2'd1,
    PH_HIGH   = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  // one result beat
  typedef struct packed {
    logic [7:0] data;
    logic       flag;   // 1: data carries a byte, 0: empty end marker
    logic       last;
  } beat_t;

  // converter result and next decode state
  typedef struct packed {
    logic [1:0] count;
    beat_t      beat2;
    beat_t      beat1;
    beat_t      beat0;
    phase_t     phase_nxt;
    logic [3:0] nibble_nxt;
  } conv_res_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c inside {[8'h30:8'h39]}) t = c - CHR_0;
      else if (c inside {[8'h41:8'h46]}) t = c - CHR_UA + 8'd10;
      else if (c inside {[8'h61:8'h66]}) t = c - CHR_LA + 8'd10;
      return t[3:0];
    end
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    begin
      if (v < 4'd10) return CHR_0 + {4'd0, v};
      return CHR_UA + {4'd0, v} - 8'd10;
    end
  endfunction

  // letters, digits and _ . ! ~ * ' ( )
  function automatic logic is_unreserved(input logic [7:0] c);
    begin
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                        8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29});
    end
  endfunction

endpackage

>>> rtl/url_percent_codec_top.sv
// url_percent_codec_top: streaming URL percent encoder / decoder.
// Input beats pass through the input register into the result buffer.
// Throughput: 1 input beat per cycle when each yields at most one result and
//   out_tready is high; an escaped byte in encode mode loads three beats.
// Reset (rst_n low, synchronous): mode = decode, decode state plain, buffers empty.
// Depends on upc_pkg and upc_conv.
module url_percent_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // mode: 0 decode, 1 encode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,      // in_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tuser,     // [0] out_valid
  output logic       out_tlast      // out_last
);

  // mode register
  logic mode_r;

  // input register: parts the input handshake from the result buffer
  logic       inv_r;
  logic [7:0] ind_r;
  logic       inl_r;

  // decode state
  upc_pkg::phase_t phase_r;
  logic [3:0]      nibble_r;

  // result buffer: up to three beats, head at slot 0
  upc_pkg::beat_t beat_r [upc_pkg::MAX_BEATS];
  logic [1:0]     cnt_r;

  upc_pkg::conv_res_t res;
  logic               out_fire;
  logic               load;
  logic               in_fire;

  upc_conv u_conv (
    .mode   (mode_r),
    .data   (ind_r),
    .last   (inl_r),
    .phase  (phase_r),
    .nibble (nibble_r),
    .res    (res)
  );

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = beat_r[0].data;
  assign out_tuser  = beat_r[0].flag;
  assign out_tlast  = beat_r[0].last;
  assign out_fire   = out_tvalid && out_tready;

  // the held byte moves into the buffer when it is empty or empties this cycle
  assign load      = inv_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire));
  assign in_tready = !inv_r || load;
  assign in_fire   = in_tvalid && in_tready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= upc_pkg::MODE_DECODE;
      inv_r    <= 1'b0;
      phase_r  <= upc_pkg::PH_PLAIN;
      nibble_r <= 4'd0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        inv_r <= 1'b1;
      end else if (load) begin
        inv_r <= 1'b0;
      end
      if (load) begin
        phase_r  <= res.phase_nxt;
        nibble_r <= res.nibble_nxt;
        cnt_r    <= res.count;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ind_r <= in_tdata;
      inl_r <= in_tlast;
    end
    if (load) begin
      beat_r[0] <= res.beat0;
      beat_r[1] <= res.beat1;
      beat_r[2] <= res.beat2;
    end else if (out_fire) begin
      // shift toward the head
      beat_r[0] <= beat_r[1];
      beat_r[1] <= beat_r[2];
    end
  end

endmodule

>>> rtl/upc_conv.sv
// upc_conv: combinational conversion of one input byte into up to three
// result beats plus the next decode state. Depends on upc_pkg.
module upc_conv (
  input  logic              mode,
  input  logic [7:0]        data,
  input  logic              last,
  input  upc_pkg::phase_t   phase,
  input  logic [3:0]        nibble,
  output upc_pkg::conv_res_t res
);

  always_comb begin
    res            = '0;
    res.phase_nxt  = upc_pkg::PH_PLAIN;
    res.nibble_nxt = 4'd0;
    if (mode == upc_pkg::MODE_ENCODE) begin
      if (upc_pkg::is_unreserved(data)) begin
        res.count = 2'd1;
        res.beat0 = '{data: data, flag: 1'b1, last: last};
      end else begin
        res.count = 2'd3;
        res.beat0 = '{data: upc_pkg::PCT_CHAR, flag: 1'b1, last: 1'b0};
        res.beat1 = '{data: upc_pkg::hex_digit(data[7:4]), flag: 1'b1, last: 1'b0};
        res.beat2 = '{data: upc_pkg::hex_digit(data[3:0]), flag: 1'b1, last: last};
      end
    end else if (phase == upc_pkg::PH_PCT && !last) begin
      res.count      = 2'd0;
      res.phase_nxt  = upc_pkg::PH_HIGH;
      res.nibble_nxt = upc_pkg::hex_value(data);
    end else if (phase == upc_pkg::PH_HIGH) begin
      res.count = 2'd1;
      res.beat0 = '{data: {nibble, upc_pkg::hex_value(data)}, flag: 1'b1, last: last};
    end else if (data == upc_pkg::PCT_CHAR) begin
      if (last) begin
        res.count = 2'd1;
        res.beat0 = '{data: 8'd0, flag: 1'b0, last: 1'b1};
      end else begin
        res.count      = 2'd0;
        res.phase_nxt  = upc_pkg::PH_PCT;
        res.nibble_nxt = nibble;
      end
    end else begin
      res.count = 2'd1;
      res.beat0 = '{data: data, flag: 1'b1, last: last};
    end
  end

endmodule
